// ===== rtl/cla_pkg.sv =====
// Package for the CRLF line assembler: sizes, character codes, opcodes and FSM states.
package cla_pkg;

  localparam int unsigned LineMaxDef = 60;

  localparam logic [7:0] ChrCr  = 8'h0D;
  localparam logic [7:0] ChrLf  = 8'h0A;
  localparam logic [7:0] ChrNul = 8'h00;

  localparam logic OpData = 1'b0;
  localparam logic OpConn = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StLoad,
    StLf
  } state_e;

endpackage

// ===== rtl/cla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/crlf_line_assembler.sv =====
// Top level of the CRLF line assembler: line store, fill count, drain FSM, output register.
//
// Received bytes are taken one per cycle while the block is idle and written into a line
// store RAM; zero bytes are dropped and a connection event clears the partial line. A CR or
// LF, or a fill of LINE_MAX-2 (the byte in hand then dropped, cut_short set), ends the line.
// A non-empty line is drained as its stored bytes followed by one LF flagged last. During a
// drain the input is stalled: each stored byte is read from the RAM (StRead) and then loaded
// into the output register (StLoad), and the LF is loaded last (StLf); an output stall holds
// the drain. The final LF can wait in the output register while new bytes are accepted.
module crlf_line_assembler #(
  parameter int unsigned LINE_MAX = cla_pkg::LineMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] line_byte_o,
  output logic       last_o,
  output logic       cut_short_o
);

  localparam int unsigned FillW = $clog2(LINE_MAX - 1);
  localparam int unsigned AddrW = $clog2(LINE_MAX);
  localparam logic [FillW-1:0] Limit = FillW'(LINE_MAX - 2);

  cla_pkg::state_e state_q, state_d;

  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] len_q, len_d;
  logic [FillW-1:0] rd_idx_q, rd_idx_d;
  logic             cut_q, cut_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_cut_q, out_cut_d;

  logic       in_accept, out_accept, out_free;
  logic       is_data, is_term, at_limit, store_byte, end_line;
  logic       ram_we, ram_re, load_byte, load_lf, rd_last;
  logic [7:0] ram_rdata;

  assign in_stall_o = (state_q != cla_pkg::StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign is_data    = (opcode_i == cla_pkg::OpData) && (data_byte_i != cla_pkg::ChrNul);
  assign is_term    = (data_byte_i == cla_pkg::ChrCr) || (data_byte_i == cla_pkg::ChrLf);
  assign at_limit   = (fill_q >= Limit);
  assign store_byte = in_accept && is_data && !is_term && !at_limit;
  assign end_line   = in_accept && is_data && (is_term || at_limit);
  assign rd_last    = ((rd_idx_q + FillW'(1)) == len_q);
  assign ram_we     = store_byte;

  cla_ram #(
    .Width(8),
    .Depth(LINE_MAX)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(fill_q)),
    .wdata_i(data_byte_i),
    .re_i   (ram_re),
    .raddr_i(AddrW'(rd_idx_q)),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cla_pkg::StIdle: begin
        if (end_line && (fill_q != '0)) begin
          state_d = cla_pkg::StRead;
        end
      end
      cla_pkg::StRead: begin
        if (out_free) begin
          state_d = cla_pkg::StLoad;
        end
      end
      cla_pkg::StLoad: begin
        state_d = rd_last ? cla_pkg::StLf : cla_pkg::StRead;
      end
      cla_pkg::StLf: begin
        if (out_free) begin
          state_d = cla_pkg::StIdle;
        end
      end
      default: state_d = cla_pkg::StIdle;
    endcase
  end

  // FSM outputs
  always_comb begin
    ram_re    = 1'b0;
    load_byte = 1'b0;
    load_lf   = 1'b0;
    case (state_q)
      cla_pkg::StRead: ram_re    = out_free;
      cla_pkg::StLoad: load_byte = 1'b1;  // out reg was freed when the read issued
      cla_pkg::StLf:   load_lf   = out_free;
      default: ;
    endcase
  end

  // line bookkeeping and output register
  always_comb begin
    fill_d      = fill_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    cut_d       = cut_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_cut_d   = out_cut_q;

    if (in_accept && (opcode_i == cla_pkg::OpConn)) begin
      fill_d = '0;
    end else if (store_byte) begin
      fill_d = fill_q + FillW'(1);
    end else if (end_line) begin
      fill_d   = '0;
      len_d    = fill_q;
      rd_idx_d = '0;
      cut_d    = !is_term;
    end

    if (out_accept) begin
      out_valid_d = 1'b0;
    end
    if (load_byte) begin
      out_valid_d = 1'b1;
      out_byte_d  = ram_rdata;
      out_last_d  = 1'b0;
      out_cut_d   = cut_q;
      rd_idx_d    = rd_idx_q + FillW'(1);
    end else if (load_lf) begin
      out_valid_d = 1'b1;
      out_byte_d  = cla_pkg::ChrLf;
      out_last_d  = 1'b1;
      out_cut_d   = cut_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cla_pkg::StIdle;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cut_q      <= cut_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_cut_q  <= out_cut_d;
  end

  assign out_valid_o = out_valid_q;
  assign line_byte_o = out_byte_q;
  assign last_o      = out_last_q;
  assign cut_short_o = out_cut_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Limit)
    else $error("fill count beyond line limit");

  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_byte_q == cla_pkg::ChrLf))
    else $error("last byte of line is not LF");

  a_end_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_line && (fill_q != '0)) |=> (state_q == cla_pkg::StRead && fill_q == '0))
    else $error("line end did not start a drain");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cla_pkg::StRead || state_q == cla_pkg::StLoad) |-> (rd_idx_q < len_q))
    else $error("drain read index past line length");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cla_pkg::StLoad) |-> !out_valid_q)
    else $error("output register overwritten while occupied");

endmodule

// ===== sim/crlf_line_assembler_tb.sv =====
// Self-checking testbench for the CRLF line assembler: random and directed byte streams.
module crlf_line_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineMax    = cla_pkg::LineMaxDef;
  localparam int unsigned FillLimit  = LineMax - 2;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainWait  = 4 * LineMax + 40;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       cut;
  } line_beat_t;

  typedef enum int {
    EndCr,
    EndLf,
    EndCrLf,
    EndCut,
    EndConn
  } line_end_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic       opcode_i    = cla_pkg::OpData;
  logic [7:0] data_byte_i = cla_pkg::ChrNul;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] line_byte_o;
  logic       last_o;
  logic       cut_short_o;

  crlf_line_assembler #(
    .LINE_MAX(LineMax)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .line_byte_o (line_byte_o),
    .last_o      (last_o),
    .cut_short_o (cut_short_o)
  );

  always #4 clk_i = ~clk_i;

  rx_req_t    rx_pending[$];
  line_beat_t beats_due[$];
  rx_req_t    next_req;
  line_beat_t got_beat;

  // predictor state
  logic [7:0] line_buf[LineMax];
  logic [5:0] line_fill = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int n_queued      = 0;
  int n_accepted    = 0;
  int n_lines       = 0;
  int n_cut_lines   = 0;
  int n_beats       = 0;
  int errors        = 0;
  int cycles        = 0;

  task automatic assemble_line(input logic op, input logic [7:0] b);
    bit is_term;
    bit is_cut;
    int k;
    if (op == cla_pkg::OpConn) begin
      line_fill = '0;
      return;
    end
    if (b == cla_pkg::ChrNul) return;
    is_term = (b == cla_pkg::ChrCr) || (b == cla_pkg::ChrLf);
    is_cut  = (line_fill >= FillLimit);
    if (!is_term && !is_cut) begin
      line_buf[line_fill] = b;
      line_fill = line_fill + 6'd1;
      return;
    end
    // a terminator at the limit still counts as a CR/LF end
    if (line_fill != 0) begin
      for (k = 0; k < int'(line_fill); k++)
        beats_due.push_back('{ch: line_buf[k], last: 1'b0, cut: !is_term});
      beats_due.push_back('{ch: cla_pkg::ChrLf, last: 1'b1, cut: !is_term});
      n_lines++;
      if (!is_term) n_cut_lines++;
    end
    line_fill = '0;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        assemble_line(opcode_i, data_byte_i);
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = rx_pending.pop_front();
          in_valid_i  <= 1'b1;
          opcode_i    <= next_req.op;
          data_byte_i <= next_req.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected line byte %02h last %0b cut_short %0b", $time,
                   line_byte_o, last_o, cut_short_o);
          errors++;
        end else begin
          got_beat = beats_due.pop_front();
          n_beats++;
          if (line_byte_o !== got_beat.ch) begin
            $display("%0t: line_byte expected %02h actual %02h", $time, got_beat.ch,
                     line_byte_o);
            errors++;
          end
          if (last_o !== got_beat.last) begin
            $display("%0t: last expected %0b actual %0b", $time, got_beat.last, last_o);
            errors++;
          end
          if (cut_short_o !== got_beat.cut) begin
            $display("%0t: cut_short expected %0b actual %0b", $time, got_beat.cut,
                     cut_short_o);
            errors++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d line bytes outstanding", $time, beats_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_req(input logic op, input logic [7:0] b);
    rx_pending.push_back('{op: op, data: b});
    if (op == cla_pkg::OpConn || b != cla_pkg::ChrNul) n_queued++;
  endtask

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == cla_pkg::ChrCr || b == cla_pkg::ChrLf);
    return b;
  endfunction

  // one line of random text, an occasional ignored zero byte, then its end
  task automatic push_line(input int len, input line_end_e how);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) push_req(cla_pkg::OpData, cla_pkg::ChrNul);
      push_req(cla_pkg::OpData, rand_text_byte());
    end
    case (how)
      EndCr:   push_req(cla_pkg::OpData, cla_pkg::ChrCr);
      EndLf:   push_req(cla_pkg::OpData, cla_pkg::ChrLf);
      EndCrLf: begin
        push_req(cla_pkg::OpData, cla_pkg::ChrCr);
        push_req(cla_pkg::OpData, cla_pkg::ChrLf);
      end
      EndCut:  push_req(cla_pkg::OpData, rand_text_byte());
      default: push_req(cla_pkg::OpConn, 8'($urandom));
    endcase
  endtask

  task automatic push_stretch(input int count);
    int stop;
    int r;
    int len;
    line_end_e how;
    stop = n_queued + count;
    while (n_queued < stop) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_req(1'($urandom), 8'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 80) len = $urandom_range(1, 8);
        else if (r < 93) len = $urandom_range(9, FillLimit - 1);
        else len = FillLimit;
        r = $urandom_range(99);
        if (len == FillLimit) begin
          how = (r < 50) ? EndCut : ((r < 75) ? EndCr : EndLf);
        end else begin
          how = (r < 35) ? EndCr : ((r < 65) ? EndLf : ((r < 93) ? EndCrLf : EndConn));
        end
        push_line(len, how);
      end
    end
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_valid_i || beats_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    @(negedge clk_i);
    send_idle_pct = idle;
    stall_pct     = stall;
    push_stretch(count);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short lines, empty lines, zero bytes, connection events
    push_req(cla_pkg::OpData, 8'h41);
    push_req(cla_pkg::OpData, cla_pkg::ChrCr);
    push_req(cla_pkg::OpData, cla_pkg::ChrCr);
    push_req(cla_pkg::OpData, cla_pkg::ChrLf);
    push_req(cla_pkg::OpData, 8'hFF);
    push_req(cla_pkg::OpData, 8'h01);
    push_req(cla_pkg::OpData, 8'h80);
    push_req(cla_pkg::OpData, 8'h7F);
    push_req(cla_pkg::OpData, cla_pkg::ChrLf);
    push_req(cla_pkg::OpData, 8'h42);
    push_req(cla_pkg::OpData, cla_pkg::ChrNul);
    push_req(cla_pkg::OpData, 8'h43);
    push_req(cla_pkg::OpData, cla_pkg::ChrCr);
    push_req(cla_pkg::OpData, cla_pkg::ChrLf);
    push_req(cla_pkg::OpData, 8'h44);
    push_req(cla_pkg::OpData, 8'h45);
    push_req(cla_pkg::OpConn, 8'hAA);
    push_req(cla_pkg::OpData, 8'h46);
    push_req(cla_pkg::OpData, cla_pkg::ChrCr);
    push_req(cla_pkg::OpConn, 8'h0D);
    push_req(cla_pkg::OpData, cla_pkg::ChrNul);
    push_req(cla_pkg::OpData, cla_pkg::ChrLf);
    wait_drained();

    // fill limit: cut then zero byte and empty line, LF arriving at the limit
    push_line(FillLimit, EndCut);
    push_req(cla_pkg::OpData, cla_pkg::ChrNul);
    push_req(cla_pkg::OpData, cla_pkg::ChrCr);
    push_line(FillLimit - 1, EndCut);
    push_req(cla_pkg::OpData, cla_pkg::ChrLf);
    wait_drained();

    run_phase(0, 0, 35);
    run_phase(82, 0, 35);
    run_phase(0, 82, 35);
    run_phase(11, 11, 35);

    // receiver holds off while lines keep coming in
    @(negedge clk_i);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = hold_req + 1;
    push_line(20, EndCr);
    push_line(12, EndLf);
    push_line(5, EndCr);
    wait_drained();

    repeat (DrainWait) @(negedge clk_i);

    $display("requests accepted: %0d, lines: %0d (%0d cut at the length limit)",
             n_accepted, n_lines, n_cut_lines);
    $display("line bytes checked: %0d, mismatches: %0d", n_beats, errors);
    if (errors == 0 && beats_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cla_pkg.sv
rtl/cla_ram.sv
rtl/crlf_line_assembler.sv
sim/crlf_line_assembler_tb.sv
